/* hdl/rbf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_pkg
// shared widths, codes and types for the radial basis node membership block
// ----------------------------------------------------------------------------
package rbf_pkg;

    // configuration
    localparam int          CFG_W        = 7;
    localparam logic [6:0]  DIMS_RESET   = 7'd64;
    localparam int          MAX_DIMS_DEF = 64;

    // field widths
    localparam int INDEX_W = 6;
    localparam int VAL_W   = 16;  // Q4.12 center and sample
    localparam int DIFF_W  = 17;  // signed difference
    localparam int MAG_W   = 16;  // magnitude of a difference
    localparam int FRAC_W  = 12;
    localparam int RAD_W   = 15;
    localparam int MODE_W  = 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAW_W   = 40;
    localparam int SCL_W   = 37;
    localparam int MEMB_W  = 25;
    localparam int DIV_N_W = MAG_W + FRAC_W;  // dividend bits, one quotient bit per step
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
    localparam int SQR_CNT_W = $clog2(MAG_W + 1);

    // saturation of the scaled quotient, as magnitudes
    localparam logic [MAG_W-1:0] SAT_POS_MAG = 16'd32767;
    localparam logic [MAG_W-1:0] SAT_NEG_MAG = 16'd32768;

    localparam logic [RAW_W-1:0]  RAW_MAX = {RAW_W{1'b1}};
    localparam logic [SCL_W-1:0]  SCL_MAX = {SCL_W{1'b1}};
    localparam logic [MEMB_W-1:0] ONE_Q24 = 25'h100_0000;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCALE    = 2'd0,
        MODE_ZERO_NEG = 2'd1,
        MODE_ZERO_POS = 2'd2,
        MODE_PLAIN    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [RAD_W-1:0]  radius;
        logic [VAL_W-1:0]  center;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHAPE,
        ST_DIV,
        ST_SQR_GO,
        ST_SQR,
        ST_ACC
    } t_state;

endpackage
`default_nettype wire

/* hdl/rbf_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_store
// per-dimension center, radius and mode memory, one write and one read port
// ----------------------------------------------------------------------------
module rbf_store #(
    parameter int MAX_DIMS = rbf_pkg::MAX_DIMS_DEF,
    parameter int AW       = $clog2(rbf_pkg::MAX_DIMS_DEF)
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  rbf_pkg::t_entry      i_wr_data,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output rbf_pkg::t_entry      o_rd_data
);
    import rbf_pkg::*;

    t_entry r_mem [MAX_DIMS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hdl/rbf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbf_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [rbf_pkg::DIV_N_W-1:0]   i_dividend,
    input  wire [rbf_pkg::RAD_W-1:0]     i_divisor,
    output logic                         o_busy,
    output logic [rbf_pkg::DIV_N_W-1:0]  o_quotient
);
    import rbf_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quo;
    logic [RAD_W-1:0]     r_rem;
    logic [RAD_W-1:0]     r_dsr;

    logic [RAD_W:0]       trial;
    logic [RAD_W+1:0]     trial_sub;
    logic                 q_bit;
    logic [RAD_W-1:0]     n_rem;

    // partial remainder with the next dividend bit shifted in
    always_comb begin
        trial     = {r_rem, r_quo[DIV_N_W-1]};
        trial_sub = {1'b0, trial} - {2'b00, r_dsr};
        q_bit     = ~trial_sub[RAD_W+1];
        n_rem     = q_bit ? trial_sub[RAD_W-1:0] : trial[RAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_N_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* hdl/rbf_sqr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_sqr
// bit-serial shift-add squarer, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rbf_sqr (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [rbf_pkg::MAG_W-1:0]   i_operand,
    output logic                       o_busy,
    output logic [rbf_pkg::SQ_W-1:0]   o_square
);
    import rbf_pkg::*;

    logic [SQR_CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]      r_mcand;
    logic [MAG_W-1:0]     r_mult;
    logic [SQ_W-1:0]      r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= SQR_CNT_W'(MAG_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= SQ_W'(i_operand);
            r_mult  <= i_operand;
            r_acc   <= '0;
        end else if (r_cnt != '0) begin
            if (r_mult[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[SQ_W-2:0], 1'b0};
            r_mult  <= {1'b0, r_mult[MAG_W-1:1]};
        end
    end

    assign o_busy   = (r_cnt != '0);
    assign o_square = r_acc;

endmodule
`default_nettype wire

/* hdl/rbf_node_membership_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_node_membership_top
// one radial basis node: per-dimension center/radius store, serial distance
// and membership over a streamed sample vector
// ----------------------------------------------------------------------------
// a load item writes center, radius and mode of one dimension (dropped
// when the index is at or beyond the dimensions in use). a sample item is
// worked one at a time: memory read, difference, then in scale mode with a
// nonzero radius a restoring divider producing one quotient bit per cycle,
// then two shift-add squarers running side by side and a saturating
// accumulate. the result of the last element waits in an output register,
// and the accumulate of a later vector's last element holds only while that
// register is still full. stores are not cleared by reset; a sample must not
// reach a dimension that was never loaded.
// ----------------------------------------------------------------------------
module rbf_node_membership_top #(
    parameter int MAX_DIMS = rbf_pkg::MAX_DIMS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_wr_en,
    input  wire [rbf_pkg::CFG_W-1:0]     i_cfg_wr_data,
    // input items
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_command,
    input  wire [rbf_pkg::INDEX_W-1:0]   i_index,
    input  wire signed [rbf_pkg::VAL_W-1:0] i_center,
    input  wire [rbf_pkg::RAD_W-1:0]     i_radius,
    input  wire [rbf_pkg::MODE_W-1:0]    i_radius_mode,
    input  wire signed [rbf_pkg::VAL_W-1:0] i_sample,
    // result items
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [rbf_pkg::RAW_W-1:0]    o_distance,
    output logic [rbf_pkg::MEMB_W-1:0]   o_membership
);
    import rbf_pkg::*;

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int EW = (DW > CFG_W) ? DW : CFG_W;

    // state
    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_dims;
    logic [AW-1:0]     r_pos;
    logic              r_emit;
    logic [VAL_W-1:0]  r_sample;
    logic              r_sign;
    logic [MAG_W-1:0]  r_mag;
    logic [MODE_W-1:0] r_mode;
    logic [RAD_W-1:0]  r_rad;
    logic [MAG_W-1:0]  r_shaped;
    logic [RAW_W-1:0]  r_raw_sum;
    logic [SCL_W-1:0]  r_scl_sum;
    logic              r_out_valid;
    logic [RAW_W-1:0]  r_distance;
    logic [MEMB_W-1:0] r_membership;

    // fsm outputs
    logic in_ready;
    logic rd_en;
    logic div_start;
    logic sqr_start;
    logic acc_en;

    logic accept;
    logic is_load;
    logic out_free;

    // effective dimension count, zero acts as one, clamped to the store depth
    logic [EW-1:0] dims_cfg;
    logic [EW-1:0] dims_eff;
    logic [EW-1:0] idx_ext;
    logic [EW-1:0] pos_next;
    logic          load_ok;

    always_comb begin
        dims_cfg = EW'(r_dims);
        if (dims_cfg == '0) begin
            dims_eff = EW'(1);
        end else if (dims_cfg > EW'(MAX_DIMS)) begin
            dims_eff = EW'(MAX_DIMS);
        end else begin
            dims_eff = dims_cfg;
        end
        idx_ext  = EW'(i_index);
        pos_next = EW'(r_pos) + EW'(1);
        load_ok  = (idx_ext < dims_eff);
    end

    assign accept  = i_valid && in_ready;
    assign is_load = (t_cmd'(i_command) == CMD_LOAD);

    // center / radius store
    t_entry wr_entry;
    t_entry rd_entry;

    assign wr_entry.mode   = i_radius_mode;
    assign wr_entry.radius = i_radius;
    assign wr_entry.center = i_center;

    rbf_store #(
        .MAX_DIMS (MAX_DIMS),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && is_load && load_ok),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_entry)
    );

    // difference of the element against its stored center
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] diff_neg;

    always_comb begin
        diff     = {r_sample[VAL_W-1], r_sample} - {rd_entry.center[VAL_W-1], rd_entry.center};
        diff_neg = '0 - diff;
    end

    // serial divider for scale mode
    logic               div_busy;
    logic [DIV_N_W-1:0] div_quo;

    rbf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_mag, {FRAC_W{1'b0}}}),
        .i_divisor  (r_rad),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // quotient magnitude saturated per the sign of the difference
    logic [MAG_W-1:0] quo_sat;

    always_comb begin
        if (r_sign) begin
            quo_sat = (div_quo > DIV_N_W'(SAT_NEG_MAG)) ? SAT_NEG_MAG : div_quo[MAG_W-1:0];
        end else begin
            quo_sat = (div_quo > DIV_N_W'(SAT_POS_MAG)) ? SAT_POS_MAG : div_quo[MAG_W-1:0];
        end
    end

    // shaped magnitude for the modes that need no division
    logic             need_div;
    logic [MAG_W-1:0] shaped_direct;

    always_comb begin
        need_div      = 1'b0;
        shaped_direct = r_mag;
        unique case (t_mode'(r_mode))
            MODE_SCALE: begin
                if (r_rad != '0) begin
                    need_div = 1'b1;
                end else if (r_mag == '0) begin
                    shaped_direct = '0;
                end else begin
                    // zero radius: saturate toward the sign of the difference
                    shaped_direct = r_sign ? SAT_NEG_MAG : SAT_POS_MAG;
                end
            end
            MODE_ZERO_NEG: shaped_direct = r_sign ? '0 : r_mag;
            MODE_ZERO_POS: shaped_direct = r_sign ? r_mag : '0;
            MODE_PLAIN:    shaped_direct = r_mag;
            default:       shaped_direct = r_mag;
        endcase
    end

    // two squarers in parallel, same length so they finish together
    logic            sqr_busy_raw;
    logic            sqr_busy_scl;
    logic [SQ_W-1:0] sq_raw;
    logic [SQ_W-1:0] sq_scl;

    rbf_sqr u_sqr_raw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqr_start),
        .i_operand (r_mag),
        .o_busy    (sqr_busy_raw),
        .o_square  (sq_raw)
    );

    rbf_sqr u_sqr_scl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqr_start),
        .i_operand (r_shaped),
        .o_busy    (sqr_busy_scl),
        .o_square  (sq_scl)
    );

    // saturating accumulate and membership
    logic [RAW_W:0]    raw_add;
    logic [SCL_W:0]    scl_add;
    logic [RAW_W-1:0]  raw_new;
    logic [SCL_W-1:0]  scl_new;
    logic [MEMB_W-1:0] memb_new;

    always_comb begin
        raw_add = {1'b0, r_raw_sum} + (RAW_W + 1)'(sq_raw);
        scl_add = {1'b0, r_scl_sum} + (SCL_W + 1)'(sq_scl);
        raw_new = (raw_add >= (RAW_W + 1)'(RAW_MAX)) ? RAW_MAX : raw_add[RAW_W-1:0];
        scl_new = (scl_add >= (SCL_W + 1)'(SCL_MAX)) ? SCL_MAX : scl_add[SCL_W-1:0];
        if (scl_new >= SCL_W'(ONE_Q24)) begin
            memb_new = '0;
        end else begin
            memb_new = ONE_Q24 - scl_new[MEMB_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept && !is_load) n_state = ST_READ;
            ST_READ:   n_state = ST_SHAPE;
            ST_SHAPE:  n_state = need_div ? ST_DIV : ST_SQR_GO;
            ST_DIV:    if (!div_busy) n_state = ST_SQR_GO;
            ST_SQR_GO: n_state = ST_SQR;
            ST_SQR:    if (!sqr_busy_raw && !sqr_busy_scl) n_state = ST_ACC;
            ST_ACC:    if (!r_emit || out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        sqr_start = 1'b0;
        acc_en    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_en    = i_valid && !is_load;
            end
            ST_READ:   ;
            ST_SHAPE:  div_start = need_div;
            ST_DIV:    ;
            ST_SQR_GO: sqr_start = 1'b1;
            ST_SQR:    ;
            ST_ACC:    acc_en = !r_emit || out_free;
            default:   ;
        endcase
    end

    assign o_stall = !in_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dims      <= DIMS_RESET;
            r_pos       <= '0;
            r_emit      <= 1'b0;
            r_raw_sum   <= '0;
            r_scl_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_dims <= i_cfg_wr_data;
            end
            // last element of the vector decided when the element is taken
            if (accept && !is_load) begin
                r_emit <= (pos_next >= dims_eff);
            end
            if (acc_en) begin
                if (r_emit) begin
                    r_pos     <= '0;
                    r_raw_sum <= '0;
                    r_scl_sum <= '0;
                end else begin
                    r_pos     <= r_pos + 1'b1;
                    r_raw_sum <= raw_new;
                    r_scl_sum <= scl_new;
                end
            end
            if (acc_en && r_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && !is_load) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_READ) begin
            r_sign <= diff[DIFF_W-1];
            r_mag  <= diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
            r_mode <= rd_entry.mode;
            r_rad  <= rd_entry.radius;
        end
        if (r_state == ST_SHAPE) begin
            r_shaped <= shaped_direct;
        end else if (r_state == ST_DIV && !div_busy) begin
            r_shaped <= quo_sat;
        end
        if (acc_en && r_emit) begin
            r_distance   <= raw_new;
            r_membership <= memb_new;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_distance   = r_distance;
    assign o_membership = r_membership;

endmodule
`default_nettype wire

/* verif/tb_rbf_node_membership_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rbf_node_membership_top
// drives load and sample items into the radial basis node, predicts the
// distance and membership of each completed sample vector in a local copy of
// the node, and checks every result item in order against that prediction
// ----------------------------------------------------------------------------
module tb_rbf_node_membership_top;
    import rbf_pkg::*;

    localparam int NODE_DIMS     = rbf_pkg::MAX_DIMS_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEM_TARGET   = 900;

    localparam longint unsigned RAW_LIMIT    = 64'(RAW_MAX);
    localparam longint unsigned SCALED_LIMIT = 64'(SCL_MAX);
    localparam longint unsigned UNIT_Q24     = 64'(ONE_Q24);

    typedef struct {
        logic [RAW_W-1:0]  distance;
        logic [MEMB_W-1:0] membership;
    } t_node_result;

    // dut signals, the inputs all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_command     = 1'b0;
    logic [INDEX_W-1:0]   i_index       = '0;
    logic [VAL_W-1:0]     i_center      = '0;
    logic [RAD_W-1:0]     i_radius      = '0;
    logic [MODE_W-1:0]    i_radius_mode = '0;
    logic [VAL_W-1:0]     i_sample      = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [RAW_W-1:0]     o_distance;
    logic [MEMB_W-1:0]    o_membership;

    // local copy of the node
    logic [VAL_W-1:0]     node_center [NODE_DIMS];
    logic [RAD_W-1:0]     node_radius [NODE_DIMS];
    t_mode                node_mode   [NODE_DIMS];
    logic [CFG_W-1:0]     dims_reg    = DIMS_RESET;
    int                   elem_pos    = 0;
    longint unsigned      dist_acc    = 0;
    longint unsigned      scaled_acc  = 0;

    t_node_result         pending_results [$];
    t_node_result         due;
    int                   mismatches   = 0;
    int                   useful_items = 0;
    int                   idle_pct     = 15;
    int                   cycle_count  = 0;

    rbf_node_membership_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_center      (i_center),
        .i_radius      (i_radius),
        .i_radius_mode (i_radius_mode),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_distance    (o_distance),
        .o_membership  (o_membership)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // dimension count as the node sees it: zero acts as one, above max clamps
    function automatic int active_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > NODE_DIMS) return NODE_DIMS;
        return int'(dims_reg);
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned add,
                                                longint unsigned lim);
        if (acc >= lim || add >= lim - acc) return lim;
        return acc + add;
    endfunction

    function automatic longint unsigned square_of(int v);
        return unsigned'(longint'(v) * longint'(v));
    endfunction

    // difference after the radius mode of its dimension
    function automatic int shape_diff(int diff, logic [RAD_W-1:0] rad, t_mode mode);
        longint quo;
        longint div_by;
        div_by = longint'(rad);
        case (mode)
            MODE_SCALE: begin
                // zero radius saturates toward the sign of the difference
                if (rad == 0) return (diff > 0) ? 32767 : ((diff < 0) ? -32768 : 0);
                quo = (longint'(diff) * 4096) / div_by;
                if (quo > 32767) quo = 32767;
                if (quo < -32768) quo = -32768;
                return int'(quo);
            end
            MODE_ZERO_NEG: return (diff < 0) ? 0 : diff;
            MODE_ZERO_POS: return (diff > 0) ? 0 : diff;
            default:       return diff;
        endcase
    endfunction

    // advance the local node by one accepted item, queue a result when due
    function automatic void predict_membership(t_cmd cmd, logic [INDEX_W-1:0] idx,
                                               logic [VAL_W-1:0] ctr, logic [RAD_W-1:0] rad,
                                               t_mode mode, logic [VAL_W-1:0] smp);
        int           eff;
        int           pos;
        int           diff;
        int           shaped;
        t_node_result res;
        eff = active_dims();
        if (cmd == CMD_LOAD) begin
            // loads at or beyond the count in use are dropped
            if (int'(idx) < eff) begin
                node_center[idx] = ctr;
                node_radius[idx] = rad;
                node_mode[idx]   = mode;
            end
            return;
        end
        pos = (elem_pos >= NODE_DIMS) ? NODE_DIMS - 1 : elem_pos;
        diff = int'($signed(smp)) - int'($signed(node_center[pos]));
        dist_acc = sat_sum(dist_acc, square_of(diff), RAW_LIMIT);
        shaped = shape_diff(diff, node_radius[pos], node_mode[pos]);
        scaled_acc = sat_sum(scaled_acc, square_of(shaped), SCALED_LIMIT);
        pos++;
        // a lowered count ends the vector at the first element past it
        if (pos < eff) begin
            elem_pos = pos;
            return;
        end
        res.distance   = dist_acc[RAW_W-1:0];
        res.membership = (scaled_acc >= UNIT_Q24) ? '0 : MEMB_W'(UNIT_Q24 - scaled_acc);
        pending_results.push_back(res);
        elem_pos   = 0;
        dist_acc   = 0;
        scaled_acc = 0;
    endfunction

    // sample near the center of the next dimension most of the time, so that
    // membership is often above zero; otherwise anywhere in range
    function automatic logic [VAL_W-1:0] pick_sample();
        int pos;
        int span;
        pos = (elem_pos >= NODE_DIMS) ? NODE_DIMS - 1 : elem_pos;
        if ($urandom_range(99) < 30) return VAL_W'($urandom);
        span = (node_mode[pos] == MODE_SCALE) ? int'(node_radius[pos] >> 1) : 1024;
        return node_center[pos] + VAL_W'($urandom_range(0, 2 * span)) - VAL_W'(span);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // result side stalls at random, except in the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    // one item on the input channel; predicted at the accepting edge
    task automatic send_item(t_cmd cmd, logic [INDEX_W-1:0] idx, logic [VAL_W-1:0] ctr,
                             logic [RAD_W-1:0] rad, t_mode mode, logic [VAL_W-1:0] smp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_index       <= idx;
        i_center      <= ctr;
        i_radius      <= rad;
        i_radius_mode <= mode;
        i_sample      <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!(cmd == CMD_LOAD && int'(idx) >= active_dims())) useful_items++;
        predict_membership(cmd, idx, ctr, rad, mode, smp);
    endtask

    // unused fields of each kind of item carry random values
    task automatic send_load(int idx, logic [VAL_W-1:0] ctr, logic [RAD_W-1:0] rad,
                             t_mode mode);
        send_item(CMD_LOAD, INDEX_W'(idx), ctr, rad, mode, VAL_W'($urandom));
    endtask

    task automatic send_sample(logic [VAL_W-1:0] smp);
        send_item(CMD_SAMPLE, INDEX_W'($urandom), VAL_W'($urandom), RAD_W'($urandom),
                  t_mode'($urandom_range(3)), smp);
    endtask

    task automatic send_random_load(int idx);
        logic [RAD_W-1:0] rad;
        case ($urandom_range(9))
            0:       rad = '0;
            1:       rad = RAD_W'(1);
            2:       rad = '1;
            3, 4:    rad = RAD_W'($urandom_range(1, 255));
            default: rad = RAD_W'($urandom_range(256, 32767));
        endcase
        send_load(idx, VAL_W'($urandom), rad, t_mode'($urandom_range(3)));
    endtask

    // wait until every result is out and the last element has settled
    task automatic drain_node();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // dimension count register, only written with the node idle
    task automatic write_dims(logic [CFG_W-1:0] value);
        drain_node();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dims_reg = value;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, distance %0h membership %0h",
                         $time, o_distance, o_membership);
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                if (o_distance !== due.distance) begin
                    $display("%0t: distance expected %0h actual %0h",
                             $time, due.distance, o_distance);
                    mismatches++;
                end
                if (o_membership !== due.membership) begin
                    $display("%0t: membership expected %0h actual %0h",
                             $time, due.membership, o_membership);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_rbf_node_membership_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // count left at its reset value of 64: opposite extremes in every
    // dimension drive the scaled sum into saturation, membership zero
    task automatic test_full_width_saturation();
        int i;
        for (i = 0; i < NODE_DIMS; i++)
            send_load(i, ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000,
                      RAD_W'($urandom), MODE_PLAIN);
        for (i = 0; i < NODE_DIMS; i++)
            send_sample(~node_center[i]);
    endtask

    // one dimension: field extremes, each mode, zero radius
    task automatic test_field_extremes();
        write_dims(7'd1);
        // quotient saturates high, then low
        send_load(0, 16'h8000, RAD_W'(1), MODE_SCALE);
        send_sample(16'h7FFF);
        send_load(0, 16'h7FFF, RAD_W'(1), MODE_SCALE);
        send_sample(16'h8000);
        // widest negative difference over the largest radius
        send_load(0, 16'h7FFF, '1, MODE_SCALE);
        send_sample(16'h8000);
        // half a radius away, membership three quarters
        send_load(0, 16'h0000, 15'h1000, MODE_SCALE);
        send_sample(16'h0800);
        // zero radius with positive, negative and zero difference
        send_load(0, 16'h0000, '0, MODE_SCALE);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        // one-sided modes, each side
        send_load(0, 16'h1000, 15'h1000, MODE_ZERO_NEG);
        send_sample(16'h0800);
        send_sample(16'h1800);
        send_load(0, 16'h1000, 15'h1000, MODE_ZERO_POS);
        send_sample(16'h1800);
        send_sample(16'h0800);
        // unscaled, inside and exactly at 1.0
        send_load(0, 16'h0000, 15'h1000, MODE_PLAIN);
        send_sample(16'h0400);
        send_sample(16'h1000);
    endtask

    // count of zero and above max, dropped loads, count lowered mid-vector
    task automatic test_dims_out_of_range();
        write_dims(7'd0);
        send_random_load(1);                // dropped, only one dimension
        send_sample(pick_sample());
        write_dims(7'd127);
        send_random_load(63);               // kept, count clamps to 64
        repeat (3) send_sample(pick_sample());
        write_dims(7'd2);
        send_random_load(2);                // dropped
        send_sample(pick_sample());         // fourth element closes the vector
    endtask

    // rounds of: new count, full load, a few vectors, with stray loads and
    // now and then a vector left open across the next count change
    task automatic test_random_vectors(int count);
        int first;
        int sel;
        int eff;
        int i;
        logic [CFG_W-1:0] value;
        first = useful_items;
        while (useful_items - first < count) begin
            // one long stretch without idling on either side
            idle_pct = (useful_items - first >= 200 && useful_items - first < 400) ? 0 : 15;
            sel = $urandom_range(99);
            if (sel < 72)      value = CFG_W'($urandom_range(1, 8));
            else if (sel < 90) value = CFG_W'($urandom_range(9, 24));
            else if (sel < 93) value = 7'd0;
            else if (sel < 96) value = 7'd64;
            else if (sel < 98) value = 7'd127;
            else               value = CFG_W'($urandom_range(25, 126));
            write_dims(value);
            eff = active_dims();
            for (i = 0; i < eff; i++) send_random_load(i);
            if (eff < NODE_DIMS && $urandom_range(3) == 0)
                send_random_load($urandom_range(eff, NODE_DIMS - 1));
            repeat ($urandom_range(1, 4)) begin
                do begin
                    if ($urandom_range(99) < 5) send_random_load($urandom_range(0, 63));
                    send_sample(pick_sample());
                end while (elem_pos != 0);
            end
            if (eff > 1 && $urandom_range(4) == 0)
                repeat ($urandom_range(1, eff - 1)) send_sample(pick_sample());
        end
        idle_pct = 15;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_width_saturation();
        test_field_extremes();
        test_dims_out_of_range();
        test_random_vectors(ITEM_TARGET - useful_items);
        drain_node();
        if (mismatches == 0) begin
            $display("tb_rbf_node_membership_top passed");
        end else begin
            $display("tb_rbf_node_membership_top failed");
        end
        $finish;
    end

endmodule

/* rbf_node_membership_top.f */
hdl/rbf_pkg.sv
hdl/rbf_store.sv
hdl/rbf_div.sv
hdl/rbf_sqr.sv
hdl/rbf_node_membership_top.sv
verif/tb_rbf_node_membership_top.sv
